// ===== rtl/idll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idll_pkg: shared types and constants
// Request and result structs, function codes and status codes.
// ----------------------------------------------------------------------------
package idll_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned SlotW    = $clog2(Capacity);
  localparam int unsigned CountW   = SlotW + 1;
  localparam int unsigned ValueW   = 32;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_GET    = 2'd2,
    FUNC_SET    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [CountW-1:0] position;
    logic [ValueW-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ValueW-1:0] data_out;
    logic [CountW-1:0] count;
  } rsp_t;

  // free-slot scanner control
  typedef struct packed {
    logic             start;
    logic             claim;
    logic             release_en;
    logic [SlotW-1:0] release_slot;
  } fs_ctl_t;

  typedef struct packed {
    logic             done;
    logic [SlotW-1:0] slot;
  } fs_sts_t;

endpackage

// ===== rtl/idll_free_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idll_free_scan: slot occupancy and free-slot search
// Holds the used bits and finds the lowest free slot, one slot per cycle.
// ----------------------------------------------------------------------------
module idll_free_scan import idll_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  fs_ctl_t ctl_i,
  output fs_sts_t sts_o
);

  logic [Capacity-1:0] used_q, used_d;
  logic [SlotW-1:0]    idx_q, idx_d;
  logic                run_q, run_d;
  logic                done_q, done_d;

  always_comb begin
    used_d = used_q;
    idx_d  = idx_q;
    run_d  = run_q;
    // done holds until the slot is claimed
    done_d = done_q;
    if (ctl_i.release_en) begin
      used_d[ctl_i.release_slot] = 1'b0;
    end
    if (ctl_i.claim) begin
      used_d[idx_q] = 1'b1;
      done_d        = 1'b0;
    end
    if (ctl_i.start) begin
      idx_d  = '0;
      run_d  = 1'b1;
      done_d = 1'b0;
    end else if (run_q) begin
      if (!used_q[idx_q]) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      idx_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      used_q <= used_d;
      idx_q  <= idx_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.slot = idx_q;

endmodule

// ===== rtl/indexed_doubly_linked_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list: positional doubly linked list
// Insert, remove, get and set at a list position over node storage.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; busy_o stays high
// until the single result is shown for one cycle on rsp_o with valid_o, which
// comes in the same cycle as busy_o falls. A request walks the links from the
// nearer end, one link-memory read per step, each step an address state
// (S_WALK) and then a registered read (S_WRD). An insert, or a set that
// appends, also waits for the slot scanner, which starts with the request and
// checks one slot per cycle from slot 0; an insert at either end does not walk,
// and a middle insert walks beside the scan. An error goes from the check
// state straight to the done state. Results cannot be held off by the receiver.
// No clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list import idll_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic valid_o,
  output rsp_t rsp_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_WALK  = 10'b0000000100,
    S_WRD   = 10'b0000001000,
    S_NODE  = 10'b0000010000,
    S_NRD   = 10'b0000100000,
    S_SCAN  = 10'b0001000000,
    S_LINK  = 10'b0010000000,
    S_LINK2 = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // node storage, one write and one registered read per memory per cycle
  logic [ValueW-1:0] val_mem  [Capacity];
  logic [SlotW-1:0]  next_mem [Capacity];
  logic [SlotW-1:0]  prev_mem [Capacity];

  logic [SlotW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  req_t              req_q, req_d;
  logic [SlotW-1:0]  cur_q, cur_d;     // slot under the walk
  logic [CountW-1:0] steps_q, steps_d; // links left to follow
  logic              fwd_q, fwd_d;
  logic [SlotW-1:0]  nslot_q, nslot_d; // newly claimed slot
  rsp_t              rsp_q, rsp_d;
  logic              valid_q, valid_d;

  // memory ports
  logic [SlotW-1:0]  rd_addr;
  logic [ValueW-1:0] val_rd_q;
  logic [SlotW-1:0]  next_rd_q, prev_rd_q;
  logic              val_we, next_we, prev_we;
  logic [SlotW-1:0]  val_wa, next_wa, prev_wa;
  logic [ValueW-1:0] val_wd;
  logic [SlotW-1:0]  next_wd, prev_wd;

  logic [SlotW-1:0]  next_we2_a, prev_we2_a;
  logic [SlotW-1:0]  next_we2_d, prev_we2_d;
  logic              link2_we;

  fs_ctl_t fs_ctl;
  fs_sts_t fs_sts;

  idll_free_scan u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (fs_ctl),
    .sts_o (fs_sts)
  );

  logic [CountW-1:0] half;
  logic [CountW-1:0] last_pos;
  logic              is_ins;
  assign half     = cnt_q >> 1;
  assign last_pos = cnt_q - 1'b1;
  assign is_ins   = (req_q.func == FUNC_INSERT) ||
                    (req_q.func == FUNC_SET && req_q.position == cnt_q);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    req_d    = req_q;
    cur_d    = cur_q;
    steps_d  = steps_q;
    fwd_d    = fwd_q;
    nslot_d  = nslot_q;
    rsp_d    = rsp_q;
    valid_d  = 1'b0;
    rd_addr  = cur_q;
    val_we   = 1'b0;
    next_we  = 1'b0;
    prev_we  = 1'b0;
    link2_we = 1'b0;
    val_wa   = cur_q;
    next_wa  = cur_q;
    prev_wa  = cur_q;
    val_wd   = req_q.data_in;
    next_wd  = '0;
    prev_wd  = '0;
    next_we2_a = cur_q;
    prev_we2_a = cur_q;
    next_we2_d = '0;
    prev_we2_d = '0;
    fs_ctl   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        rsp_d.status   = ST_OK;
        rsp_d.data_out = '0;
        state_d        = S_SCAN;
        if (req_q.func == FUNC_INSERT) begin
          if (cnt_q >= CountW'(Capacity)) begin
            rsp_d.status = ST_FULL;
            state_d      = S_DONE;
          end else if (cnt_q != '0 && req_q.position > cnt_q) begin
            rsp_d.status = ST_RANGE;
            state_d      = S_DONE;
          end
        end else if (cnt_q == '0 ||
                     (req_q.func != FUNC_SET && req_q.position >= cnt_q) ||
                     (req_q.func == FUNC_SET && req_q.position > cnt_q)) begin
          rsp_d.status = ST_RANGE;
          state_d      = S_DONE;
        end else if (req_q.func == FUNC_SET && req_q.position == cnt_q &&
                     cnt_q >= CountW'(Capacity)) begin
          rsp_d.status = ST_FULL;
          state_d      = S_DONE;
        end
        if (state_d == S_SCAN) begin
          if (is_ins) begin
            fs_ctl.start = 1'b1;
            if (cnt_q == '0) req_d.position = '0;
          end
          // positions at either end need no walk
          if (req_q.position <= half) begin
            fwd_d   = 1'b1;
            cur_d   = head_q;
            steps_d = req_q.position;
          end else begin
            fwd_d   = 1'b0;
            cur_d   = tail_q;
            steps_d = last_pos - req_q.position;
          end
          if (!is_ins) state_d = S_WALK;
          else if (req_q.position == '0 || req_q.position == cnt_q || cnt_q == '0) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (steps_q == '0) begin
          state_d = S_NODE;
        end else begin
          rd_addr = cur_q;
          state_d = S_WRD;
        end
      end
      S_WRD: begin
        cur_d   = fwd_q ? next_rd_q : prev_rd_q;
        steps_d = steps_q - 1'b1;
        state_d = S_WALK;
      end
      S_NODE: begin
        rd_addr = cur_q;
        state_d = S_NRD;
      end
      S_NRD: begin
        // cur is the target slot; its links and value are in the read regs
        if (is_ins) begin
          state_d = S_SCAN;
        end else begin
          rsp_d.data_out = val_rd_q;
          state_d        = S_DONE;
          unique case (req_q.func)
            FUNC_SET: begin
              val_we = 1'b1;
            end
            FUNC_REMOVE: begin
              fs_ctl.release_en   = 1'b1;
              fs_ctl.release_slot = cur_q;
              cnt_d = cnt_q - 1'b1;
              if (cnt_q == CountW'(1)) begin
                head_d = '0;
                tail_d = '0;
              end else if (req_q.position == '0) begin
                head_d = next_rd_q;
              end else if (req_q.position == last_pos) begin
                tail_d = prev_rd_q;
              end else begin
                next_we = 1'b1;
                next_wa = prev_rd_q;
                next_wd = next_rd_q;
                prev_we = 1'b1;
                prev_wa = next_rd_q;
                prev_wd = prev_rd_q;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (fs_sts.done) begin
          fs_ctl.claim = 1'b1;
          nslot_d      = fs_sts.slot;
          state_d      = S_LINK;
        end
      end
      S_LINK: begin
        val_we  = 1'b1;
        val_wa  = nslot_q;
        next_we = 1'b1;
        next_wa = nslot_q;
        prev_we = 1'b1;
        prev_wa = nslot_q;
        cnt_d   = cnt_q + 1'b1;
        state_d = S_DONE;
        if (cnt_q == '0) begin
          head_d = nslot_q;
          tail_d = nslot_q;
        end else if (req_q.position == '0) begin
          next_wd  = head_q;
          link2_we = 1'b1;
          prev_we2_a = head_q;
          prev_we2_d = nslot_q;
          head_d   = nslot_q;
        end else if (req_q.position == cnt_q) begin
          prev_wd  = tail_q;
          link2_we = 1'b1;
          next_we2_a = tail_q;
          next_we2_d = nslot_q;
          tail_d   = nslot_q;
        end else begin
          // middle: p = prev of cur, still in the read register
          next_wd = cur_q;
          prev_wd = prev_rd_q;
          state_d = S_LINK2;
        end
      end
      S_LINK2: begin
        next_we = 1'b1;
        next_wa = prev_rd_q;
        next_wd = nslot_q;
        prev_we = 1'b1;
        prev_wa = cur_q;
        prev_wd = nslot_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        rsp_d.count = cnt_q;
        valid_d     = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // second link write for end inserts goes to the old end node
  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    if (next_we && !(link2_we && req_q.position == cnt_q)) next_mem[next_wa] <= next_wd;
    else if (link2_we) next_mem[next_we2_a] <= next_we2_d;
    if (prev_we && !(link2_we && req_q.position == '0)) prev_mem[prev_wa] <= prev_wd;
    else if (link2_we) prev_mem[prev_we2_a] <= prev_we2_d;
    val_rd_q  <= val_mem[rd_addr];
    next_rd_q <= next_mem[rd_addr];
    prev_rd_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    cur_q   <= cur_d;
    steps_q <= steps_d;
    fwd_q   <= fwd_d;
    nslot_q <= nslot_d;
    rsp_q   <= rsp_d;
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(Capacity)) else $error("count over capacity");
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result while busy");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (cnt_q == $past(cnt_q))) else $error("count moved idle");
`endif

endmodule

// ===== dv/tb_indexed_doubly_linked_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_doubly_linked_list: self-checking bench for the positional list
// Directed corner requests, then random traffic that fills, churns and drains
// the list. A shadow list predicts each response, and an in-order scoreboard
// checks every field of every response.
// ----------------------------------------------------------------------------
module tb_indexed_doubly_linked_list;
  import idll_pkg::*;

  localparam int unsigned WdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic valid_o;
  rsp_t rsp_o;

  indexed_doubly_linked_list dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow list, index 0 is the head; a plain array is enough since the
  // response does not depend on which slot a node sits in
  logic [ValueW-1:0] shadow_list[$];
  req_t              pending_reqs[$];
  rsp_t              expected_rsps[$];
  int unsigned       mismatch_cnt = 0;
  int unsigned       rsp_cnt = 0;
  int unsigned       req_cnt = 0;
  int unsigned       idle_cnt = 0;
  int unsigned       max_fill = 0;
  int unsigned       op_hits[4] = '{0, 0, 0, 0};
  bit                stim_done = 1'b0;
  bit                hold_off = 1'b0;

  // model one request against the shadow list and return its response
  function automatic rsp_t list_apply(req_t r);
    rsp_t        rs;
    int unsigned n;
    int unsigned p;
    n = shadow_list.size();
    p = r.position;
    rs = '0;
    rs.status = ST_OK;
    case (func_e'(r.func))
      FUNC_INSERT: begin
        if (n >= Capacity) rs.status = ST_FULL;
        else if (n == 0) shadow_list.push_back(r.data_in);
        else if (p > n) rs.status = ST_RANGE;
        else shadow_list.insert(p, r.data_in);
      end
      FUNC_REMOVE: begin
        if (n == 0 || p >= n) rs.status = ST_RANGE;
        else begin
          rs.data_out = shadow_list[p];
          shadow_list.delete(p);
        end
      end
      FUNC_GET: begin
        if (n == 0 || p >= n) rs.status = ST_RANGE;
        else rs.data_out = shadow_list[p];
      end
      default: begin
        if (n == 0 || p > n) rs.status = ST_RANGE;
        else if (p == n) begin
          // set one past the tail appends, unless the list is full
          if (n >= Capacity) rs.status = ST_FULL;
          else shadow_list.push_back(r.data_in);
        end else begin
          rs.data_out = shadow_list[p];
          shadow_list[p] = r.data_in;
        end
      end
    endcase
    rs.count = CountW'(shadow_list.size());
    return rs;
  endfunction

  function automatic req_t mk_req(func_e f, int unsigned p, logic [ValueW-1:0] d);
    req_t r;
    r.func = f;
    r.position = CountW'(p);
    r.data_in = d;
    return r;
  endfunction

  // random request; cnt is the list size the generator tracks, and the
  // position is mostly legal so the walk goes deep into the chain
  function automatic req_t rand_req(int unsigned cnt, int unsigned bias_ins);
    func_e       f;
    int unsigned p;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < bias_ins) f = FUNC_INSERT;
    else if (sel < bias_ins + 25) f = FUNC_REMOVE;
    else f = ($urandom_range(1)) ? FUNC_GET : FUNC_SET;
    sel = $urandom_range(99);
    if (sel < 8) p = $urandom_range(511);
    else if (sel < 14) p = cnt;
    else if (sel < 20) p = (cnt > 0) ? cnt - 1 : 0;
    else if (sel < 26) p = 0;
    else p = (cnt > 0) ? $urandom_range(cnt - 1) : 0;
    return mk_req(f, p, $urandom());
  endfunction

  // stimulus: directed corners, then random phases that fill, churn and drain
  initial begin
    int unsigned cnt;
    int unsigned bias;
    req_t        r;
    // directed requests on the empty list
    pending_reqs.push_back(mk_req(FUNC_REMOVE, 0, '1));
    pending_reqs.push_back(mk_req(FUNC_GET, 0, '0));
    pending_reqs.push_back(mk_req(FUNC_SET, 0, 32'h1234_5678));
    // insert into empty list ignores the position
    pending_reqs.push_back(mk_req(FUNC_INSERT, 511, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_req(FUNC_INSERT, 0, 32'h0000_0000));
    pending_reqs.push_back(mk_req(FUNC_INSERT, 2, 32'hA5A5_5A5A));
    pending_reqs.push_back(mk_req(FUNC_INSERT, 1, 32'h5A5A_A5A5));
    // insert past the end
    pending_reqs.push_back(mk_req(FUNC_INSERT, 9, 32'h1));
    // set appends at position == count, then out of range past it
    pending_reqs.push_back(mk_req(FUNC_SET, 4, 32'hDEAD_BEEF));
    pending_reqs.push_back(mk_req(FUNC_SET, 6, 32'h2));
    pending_reqs.push_back(mk_req(FUNC_SET, 2, 32'hCAFE_F00D));
    pending_reqs.push_back(mk_req(FUNC_GET, 4, 32'h0));
    pending_reqs.push_back(mk_req(FUNC_GET, 5, 32'h0));
    pending_reqs.push_back(mk_req(FUNC_GET, 256, 32'h0));
    pending_reqs.push_back(mk_req(FUNC_REMOVE, 5, 32'h0));
    pending_reqs.push_back(mk_req(FUNC_REMOVE, 2, 32'h0));
    pending_reqs.push_back(mk_req(FUNC_REMOVE, 3, 32'h0));
    pending_reqs.push_back(mk_req(FUNC_REMOVE, 0, 32'h0));
    // track the generator's count through the directed requests
    cnt = 0;
    foreach (pending_reqs[i]) begin
      if (pending_reqs[i].func == FUNC_INSERT && (cnt == 0 || pending_reqs[i].position <= cnt))
        cnt++;
      else if (pending_reqs[i].func == FUNC_SET && cnt > 0 && pending_reqs[i].position == cnt)
        cnt++;
      else if (pending_reqs[i].func == FUNC_REMOVE && pending_reqs[i].position < cnt)
        cnt--;
    end
    // random phases: fill to full, churn at full, drain, then mixed
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 450; k++) begin
        case (ph)
          0: bias = 80;
          1: bias = 50;
          2: bias = 10;
          default: bias = 40;
        endcase
        r = rand_req(cnt, bias);
        if (r.func == FUNC_INSERT && cnt < Capacity && (cnt == 0 || r.position <= cnt))
          cnt++;
        else if (r.func == FUNC_SET && cnt > 0 && cnt < Capacity && r.position == cnt)
          cnt++;
        else if (r.func == FUNC_REMOVE && r.position < cnt)
          cnt--;
        pending_reqs.push_back(r);
      end
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: bursts with random gaps, and one hold-off until all responses are back
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_rsps.push_back(list_apply(req_i));
        op_hits[req_i.func]++;
        if (shadow_list.size() > max_fill) max_fill = shadow_list.size();
        req_cnt++;
        if (req_cnt == 900) hold_off <= 1'b1;
      end
      if (hold_off && expected_rsps.size() == 0 && !(start_i && !busy_o))
        hold_off <= 1'b0;
      if (start_i && busy_o) begin
        // request still waiting for acceptance
      end else if (hold_off || (req_cnt == 900 && start_i && !busy_o)) begin
        start_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_i <= pending_reqs.pop_front();
        start_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(12, 1);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start_i <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // monitor: every strobe pops the oldest expectation
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && valid_o) begin
      rsp_cnt++;
      if (expected_rsps.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected response %p", rsp_o);
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (rsp_o.status !== exp_rsp.status || rsp_o.data_out !== exp_rsp.data_out ||
            rsp_o.count !== exp_rsp.count) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch #%0d: exp st=%0d d=%h c=%0d got st=%0d d=%h c=%0d",
                     rsp_cnt, exp_rsp.status, exp_rsp.data_out, exp_rsp.count,
                     rsp_o.status, rsp_o.data_out, rsp_o.count);
        end
      end
    end
  end

  // watchdog on cycles without any acceptance or response
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o || !rst_ni) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
  end

  initial begin
    wait (stim_done && expected_rsps.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("requests %0d (ins %0d rem %0d get %0d set %0d), deepest list %0d",
             req_cnt, op_hits[0], op_hits[1], op_hits[2], op_hits[3], max_fill);
    $display("responses checked %0d, mismatches %0d", rsp_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
      $display("tb_indexed_doubly_linked_list: clean");
    end else begin
      $display("tb_indexed_doubly_linked_list: errors");
    end
    $finish;
  end

  initial begin
    wait (idle_cnt >= WdogLimit);
    $display("watchdog expired, %0d responses outstanding", expected_rsps.size());
    $display("tb_indexed_doubly_linked_list: errors");
    $finish;
  end

endmodule
